// ----- sv/bslp_pkg.sv -----
package bslp_pkg;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_LOW  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_DEGLITCH = 2'd1,
    REG_LONG     = 2'd2
  } reg_idx_e;

  localparam logic [2:0]  EVENT_NONE     = 3'd0;
  localparam logic [2:0]  EVENT_LONG_OFS = 3'd3;

  localparam logic [1:0]  MODE_RESET     = 2'd1;
  localparam logic [15:0] DEGLITCH_RESET = 16'd100;
  localparam logic [15:0] LONG_RESET     = 16'd750;

  // controls for one countdown
  typedef struct packed {
    logic load;  // sample changed: reload and arm
    logic step;  // unchanged tick: count down if armed
    logic kill;  // force disarm
  } cnt_ctrl_t;

endpackage

// ----- sv/bslp_countdown.sv -----
module bslp_countdown (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  bslp_pkg::cnt_ctrl_t ctrl_i,
  input  logic [15:0]       load_val_i,
  output logic              armed_o,
  output logic              expire_o
);

  logic [15:0] left_q, left_d;
  logic        armed_q, armed_d;

  // expires on a step while armed when count is one or zero
  assign expire_o = ctrl_i.step && armed_q && (left_q <= 16'd1);
  assign armed_o  = armed_q;

  always_comb begin
    left_d  = left_q;
    armed_d = armed_q;
    if (ctrl_i.load) begin
      left_d  = load_val_i;
      armed_d = 1'b1;
    end else if (ctrl_i.step && armed_q) begin
      if (left_q <= 16'd1) begin
        left_d  = 16'd0;
        armed_d = 1'b0;
      end else begin
        left_d = left_q - 16'd1;
      end
    end
    if (ctrl_i.kill) begin
      left_d  = 16'd0;
      armed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= 16'd0;
      armed_q <= 1'b0;
    end else if (en_i) begin
      left_q  <= left_d;
      armed_q <= armed_d;
    end
  end

endmodule

// ----- sv/bslp_core.sv -----
module bslp_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [1:0]  mode_i,
  input  logic [15:0] deglitch_ticks_i,
  input  logic [15:0] long_ticks_i,
  input  logic [1:0]  pins_i,
  output logic [2:0]  event_code_o,
  output logic [1:0]  stable_buttons_o
);

  logic [1:0] last_q, last_d;
  logic [1:0] stable_q, stable_d;
  logic [1:0] buttons;
  logic [1:0] released;
  logic       active, change;
  logic       dg_exp, lg_exp, lg_armed, dg_armed;
  logic       short_ev, long_ev;
  bslp_pkg::cnt_ctrl_t dg_ctrl, lg_ctrl;

  always_comb begin
    active  = 1'b1;
    buttons = 2'b00;
    case (bslp_pkg::mode_e'(mode_i))
      bslp_pkg::MODE_HIGH: buttons = pins_i;
      bslp_pkg::MODE_LOW:  buttons = {1'b0, ~pins_i[0]};
      default:             active  = 1'b0;
    endcase
  end

  assign change   = active && (buttons != last_q);
  assign released = stable_q & ~buttons;
  assign short_ev = dg_exp && (released != 2'b00) && lg_armed;
  assign long_ev  = lg_exp && !short_ev;

  assign dg_ctrl = '{load: change, step: active && !change, kill: 1'b0};
  assign lg_ctrl = '{load: change, step: active && !change, kill: short_ev};

  bslp_countdown u_deglitch (
    .clk_i,
    .rst_ni,
    .en_i,
    .ctrl_i     (dg_ctrl),
    .load_val_i (deglitch_ticks_i),
    .armed_o    (dg_armed),
    .expire_o   (dg_exp)
  );

  bslp_countdown u_long (
    .clk_i,
    .rst_ni,
    .en_i,
    .ctrl_i     (lg_ctrl),
    .load_val_i (long_ticks_i),
    .armed_o    (lg_armed),
    .expire_o   (lg_exp)
  );

  always_comb begin
    last_d       = change ? buttons : last_q;
    stable_d     = stable_q;
    event_code_o = bslp_pkg::EVENT_NONE;
    if (dg_exp) begin
      stable_d = buttons;
    end
    if (short_ev) begin
      event_code_o = {1'b0, released};
    end
    if (long_ev) begin
      stable_d = 2'b00;
      if (buttons != 2'b00) begin
        event_code_o = {1'b0, buttons} + bslp_pkg::EVENT_LONG_OFS;
      end
    end
    // deglitch armed state only matters inside the countdown
    if (!dg_armed) begin
      stable_d = stable_d;
    end
  end

  assign stable_buttons_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 2'b00;
      stable_q <= 2'b00;
    end else if (en_i) begin
      last_q   <= last_d;
      stable_q <= stable_d;
    end
  end

endmodule

// ----- sv/button_short_long_press_classifier_top.sv -----
// button short/long press classifier: one transaction on the input channel is
// one millisecond tick with the two raw button pins, and each tick produces
// exactly one output transaction carrying an event code (0 none, 1-3 short
// release of user/dfu/both, 4-6 long hold of user/dfu/both) and the debounced
// button mask. a tick passes through an input register, then the classifier
// logic updates its state and fills the result register, so the result is
// valid once the tick has moved on from the input register into the result
// register, and a new tick is accepted every cycle while the output side
// keeps taking results. with the output stalled the two registers hold two
// ticks before the input backs up. configuration registers (0 mode,
// 1 deglitch ticks, 2 long ticks) are written through a plain write port and
// are only to be changed while no tick is in flight.
module button_short_long_press_classifier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // tick input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  raw_pins_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_code_o,
  output logic [1:0]  stable_buttons_o
);

  // configuration registers
  logic [1:0]  mode_q;
  logic [15:0] deglitch_q;
  logic [15:0] long_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= bslp_pkg::MODE_RESET;
      deglitch_q <= bslp_pkg::DEGLITCH_RESET;
      long_q     <= bslp_pkg::LONG_RESET;
    end else if (cfg_we_i) begin
      case (bslp_pkg::reg_idx_e'(cfg_idx_i))
        bslp_pkg::REG_MODE:     mode_q     <= cfg_data_i[1:0];
        bslp_pkg::REG_DEGLITCH: deglitch_q <= cfg_data_i;
        bslp_pkg::REG_LONG:     long_q     <= cfg_data_i;
        default:                ;
      endcase
    end
  end

  // input register
  logic       s1_valid_q;
  logic [1:0] s1_pins_q;
  // result register
  logic       out_valid_q;
  logic [2:0] code_q;
  logic [1:0] stable_q;

  logic       advance;
  logic [2:0] code_d;
  logic [1:0] stable_d;

  // the tick in the input register moves on when the result slot is free
  // or is being emptied this cycle
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_pins_q <= raw_pins_i;
    end
  end

  // classifier state advances only when a tick moves into the result register
  bslp_core u_core (
    .clk_i,
    .rst_ni,
    .en_i             (advance),
    .mode_i           (mode_q),
    .deglitch_ticks_i (deglitch_q),
    .long_ticks_i     (long_q),
    .pins_i           (s1_pins_q),
    .event_code_o     (code_d),
    .stable_buttons_o (stable_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      code_q   <= code_d;
      stable_q <= stable_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_code_o     = code_q;
  assign stable_buttons_o = stable_q;

  // short and long never reported in one tick, so code seven never shows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_code_o != 3'd7))
    else $error("invalid event code on output");

  // a tick that moves on always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after advance");

  // backpressure on the input only while a tick is held in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without cause");

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bslp_pkg::*;

  // mode value outside the enum, treated by the block as disabled
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int TARGET_TICKS  = 750;
  localparam int RX_HOLD       = 400;   // long output stall, in cycles
  localparam int MAX_RUN       = 60;    // longest run of one pin value in random stimulus
  localparam int MAX_PRINTED   = 40;    // mismatch lines shown, all are counted
  localparam int DRAIN_CYCLES  = 3;     // settle time after the last result

  // one result transaction: event code plus debounced mask
  typedef struct packed {
    logic [2:0] code;
    logic [1:0] mask;
  } tick_result_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  // directed stimulus row: either a tick or a register write
  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  pins;
    reg_idx_e    reg_sel;
    logic [15:0] value;
    logic        typed;      // expectation given in the row itself
    logic [2:0]  exp_code;
    logic [1:0]  exp_mask;
  } dir_row_t;

  // block ports, every input known from time zero
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = 2'd0;
  logic [15:0] cfg_data_i  = 16'd0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  raw_pins_i  = 2'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  event_code_o;
  logic [1:0]  stable_buttons_o;

  button_short_long_press_classifier_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .raw_pins_i       (raw_pins_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_code_o     (event_code_o),
    .stable_buttons_o (stable_buttons_o)
  );

  // predictor copy of the configuration registers
  logic [1:0]  cur_mode     = MODE_RESET;
  logic [15:0] cur_deglitch = DEGLITCH_RESET;
  logic [15:0] cur_long     = LONG_RESET;

  // predictor copy of the classifier state
  logic [1:0]  seen_buttons  = 2'd0;
  logic [1:0]  debounced     = 2'd0;
  logic [15:0] deglitch_cnt  = 16'd0;
  logic        deglitch_run  = 1'b0;
  logic [15:0] hold_cnt      = 16'd0;
  logic        hold_run      = 1'b0;

  // results still owed by the block, oldest first
  tick_result_t pending_events[$];

  int  mismatches  = 0;
  int  cycle_count = 0;
  int  ticks_sent  = 0;
  bit  tx_burst    = 1'b0;  // sender offers back to back
  bit  rx_burst    = 1'b0;  // receiver always ready
  bit  rx_hold_req = 1'b0;  // ask the receiver for one long stall

  // directed part: reset behavior, every event kind, each mode, zero and
  // full-scale countdown registers
  localparam int N_DIR = 37;
  dir_row_t dir_rows [N_DIR] = '{
    // first tick after reset: nothing armed, nothing to report
    '{ROW_TICK, 2'd0, REG_MODE,     16'd0,        1'b1, EVENT_NONE, 2'd0},
    '{ROW_CFG,  2'd0, REG_DEGLITCH, 16'd2,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_CFG,  2'd0, REG_LONG,     16'd4,        1'b0, EVENT_NONE, 2'd0},
    // user held until the long countdown runs out
    '{ROW_TICK, 2'd1, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd1, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd1, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd1, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd1, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    // both pressed then released early: both short
    '{ROW_TICK, 2'd3, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd3, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd3, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd0, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd0, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd0, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    // dfu short
    '{ROW_TICK, 2'd2, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd2, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd2, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd0, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd0, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd0, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    // active-low single button, dfu pin must be ignored
    '{ROW_CFG,  2'd0, REG_MODE,     MODE_LOW,     1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd0, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd2, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd0, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    // disabled and unknown modes hold all state
    '{ROW_CFG,  2'd0, REG_MODE,     MODE_OFF,     1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd3, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_CFG,  2'd0, REG_MODE,     MODE_UNKNOWN, 1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd1, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    // zero countdowns act as one: both expire on the first quiet tick
    '{ROW_CFG,  2'd0, REG_MODE,     MODE_HIGH,    1'b0, EVENT_NONE, 2'd0},
    '{ROW_CFG,  2'd0, REG_DEGLITCH, 16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_CFG,  2'd0, REG_LONG,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd2, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd2, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    // full-scale countdowns just load and count
    '{ROW_CFG,  2'd0, REG_DEGLITCH, 16'hFFFF,     1'b0, EVENT_NONE, 2'd0},
    '{ROW_CFG,  2'd0, REG_LONG,     16'hFFFF,     1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd3, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0},
    '{ROW_TICK, 2'd3, REG_MODE,     16'd0,        1'b0, EVENT_NONE, 2'd0}
  };

  // clock
  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // advance one tick through the predictor and return what the block owes
  function automatic tick_result_t classify_tick(input logic [1:0] pins);
    tick_result_t res;
    logic [1:0]   btn;
    logic [1:0]   released;
    logic         deglitch_done;
    logic         hold_done;
    res.code = EVENT_NONE;
    if (cur_mode == MODE_HIGH) begin
      btn = pins;
    end else if (cur_mode == MODE_LOW) begin
      btn = pins[0] ? 2'b00 : 2'b01;
    end else begin
      // disabled or unknown mode: state frozen
      res.mask = debounced;
      return res;
    end
    if (btn != seen_buttons) begin
      // any change restarts both countdowns
      seen_buttons = btn;
      deglitch_cnt = cur_deglitch;
      deglitch_run = 1'b1;
      hold_cnt     = cur_long;
      hold_run     = 1'b1;
    end else begin
      deglitch_done = 1'b0;
      hold_done     = 1'b0;
      if (deglitch_run) begin
        if (deglitch_cnt <= 16'd1) deglitch_done = 1'b1;
        else deglitch_cnt = deglitch_cnt - 16'd1;
      end
      if (hold_run) begin
        if (hold_cnt <= 16'd1) hold_done = 1'b1;
        else hold_cnt = hold_cnt - 16'd1;
      end
      if (deglitch_done) begin
        released     = (btn ^ debounced) & debounced;
        deglitch_run = 1'b0;
        deglitch_cnt = 16'd0;
        // a release before the hold timer runs out is a short press
        if (released != 2'b00 && hold_run) begin
          res.code  = {1'b0, released};
          hold_run  = 1'b0;
          hold_cnt  = 16'd0;
          hold_done = 1'b0;
        end
        debounced = btn;
      end
      if (hold_run && hold_done) begin
        if (btn != 2'b00) res.code = {1'b0, btn} + EVENT_LONG_OFS;
        debounced = 2'b00;
        hold_run  = 1'b0;
        hold_cnt  = 16'd0;
      end
    end
    res.mask = debounced;
    return res;
  endfunction

  // idle stretch: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // countdown register value: mostly small so events happen often
  function automatic logic [15:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 16'd0;
    if (r < 75) return 16'($urandom_range(1, 6));
    if (r < 92) return 16'($urandom_range(7, 40));
    return 16'($urandom_range(41, 65535));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTED)
      $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // offer one tick and hold it until taken; returns at the falling edge after
  // acceptance with valid still high unless a gap follows
  task automatic send_tick(input logic [1:0] pins, input logic typed,
                           input tick_result_t typed_res);
    tick_result_t res;
    int           gap;
    in_valid_i <= 1'b1;
    raw_pins_i <= pins;
    do @(posedge clk_i); while (!in_ready_o);
    res = classify_tick(pins);
    pending_events.push_back(typed ? typed_res : res);
    ticks_sent++;
    @(negedge clk_i);
    gap = tx_burst ? 0 : (($urandom_range(0, 99) < 55) ? 0 : idle_len());
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // stop offering and wait until every owed result has come out
  task automatic go_idle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // register write, only called while idle
  task automatic write_reg(input reg_idx_e sel, input logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= value;
    case (sel)
      REG_MODE:     cur_mode     = value[1:0];
      REG_DEGLITCH: cur_deglitch = value;
      REG_LONG:     cur_long     = value;
      default:      ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // output side: random back pressure, quiet stretches, one long hold
  initial begin
    @(negedge clk_i);
    forever begin
      if (rx_hold_req) begin
        // long hold counted here so the sender keeps pushing into a full block
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (RX_HOLD) @(negedge clk_i);
      end else if (rx_burst || $urandom_range(0, 99) < 60) begin
        out_ready_i <= 1'b1;
        @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat (idle_len()) @(negedge clk_i);
      end
    end
  end

  // result checker: compare every output transaction with the oldest owed one
  always @(posedge clk_i) begin
    tick_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        report_mismatch("result with no tick pending, event_code", int'(event_code_o), 0);
      end else begin
        want = pending_events.pop_front();
        if (event_code_o !== want.code)
          report_mismatch("event_code", int'(event_code_o), int'(want.code));
        if (stable_buttons_o !== want.mask)
          report_mismatch("stable_buttons", int'(stable_buttons_o), int'(want.mask));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // main sequence
  initial begin
    int           phase;
    int           counted;
    int           n_ticks;
    int           k;
    int           run_len;
    int           pick;
    int           dg_eff;
    int           lg_eff;
    logic [1:0]   run_pins;
    logic [1:0]   mode_sel;
    logic [13:0]  junk;
    bit           counts;
    tick_result_t typed_res;

    // reset held low, then released on a falling edge
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        go_idle();
        write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
      end else begin
        typed_res.code = dir_rows[i].exp_code;
        typed_res.mask = dir_rows[i].exp_mask;
        send_tick(dir_rows[i].pins, dir_rows[i].typed, typed_res);
      end
    end

    // random phases: new settings, then runs of held pin values
    counted = 0;
    phase   = 0;
    while (counted < TARGET_TICKS) begin
      go_idle();
      pick = $urandom_range(0, 99);
      if (pick < 45)      mode_sel = MODE_HIGH;
      else if (pick < 85) mode_sel = MODE_LOW;
      else if (pick < 93) mode_sel = MODE_OFF;
      else                mode_sel = MODE_UNKNOWN;
      if (phase == 2) mode_sel = MODE_HIGH;
      // upper data bits are don't-care for the mode register
      junk = 14'($urandom);
      write_reg(REG_MODE, {junk, mode_sel});
      go_idle();
      write_reg(REG_DEGLITCH, pick_count());
      go_idle();
      write_reg(REG_LONG, pick_count());

      counts   = (mode_sel == MODE_HIGH) || (mode_sel == MODE_LOW);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      n_ticks  = counts ? $urandom_range(20, 80) : $urandom_range(3, 8);
      if (phase == 2) begin
        // output stalls for a long while, input keeps coming until it backs up
        tx_burst    = 1'b1;
        rx_hold_req = 1'b1;
        n_ticks     = 60;
      end

      dg_eff = (cur_deglitch == 16'd0) ? 1 : int'(cur_deglitch);
      lg_eff = (cur_long == 16'd0) ? 1 : int'(cur_long);
      k = 0;
      while (k < n_ticks) begin
        run_pins = 2'($urandom);
        pick     = $urandom_range(0, 99);
        if (pick < 20)      run_len = $urandom_range(1, 2);          // bounce noise
        else if (pick < 50) run_len = dg_eff + $urandom_range(0, 2); // just past deglitch
        else if (pick < 75) run_len = lg_eff + $urandom_range(0, 2); // just past long
        else                run_len = $urandom_range(1, 12);
        if (run_len > MAX_RUN) run_len = MAX_RUN;
        for (int j = 0; j < run_len && k < n_ticks; j++) begin
          send_tick(run_pins, 1'b0, '0);
          k++;
          if (counts) counted++;
        end
      end
      phase++;
    end

    // drain everything still owed, then let the pipeline settle
    tx_burst = 1'b0;
    rx_burst = 1'b1;
    go_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/bslp_pkg.sv
sv/bslp_countdown.sv
sv/bslp_core.sv
sv/button_short_long_press_classifier_top.sv
tb/testbench.sv
